@@ sv/sh_pkg.sv @@
// Shared types, constants and round function for the SipHash MAC engine.
`timescale 1ns / 1ps

package sh_pkg;

  localparam logic [63:0] SIP_INIT_A    = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_INIT_B    = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_INIT_C    = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_INIT_D    = 64'h7465646279746573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;
  localparam int          SIP_LEN_SHIFT = 56;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic        start;   // first word of a message: load lanes from key
    logic        absorb;  // absorb word as a full 8-byte block
    logic        last;    // final block follows, then finalization
    logic [63:0] word;
    logic [63:0] block;   // tail bytes merged with length byte
  } entry_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  // One SipRound over the four lanes.
  function automatic lanes_t lane_round(input lanes_t v);
    lanes_t w;
    w = v;
    w.a = w.a + w.b;
    w.b = rotl(w.b, 13) ^ w.a;
    w.a = rotl(w.a, 32);
    w.c = w.c + w.d;
    w.d = rotl(w.d, 16) ^ w.c;
    w.a = w.a + w.d;
    w.d = rotl(w.d, 21) ^ w.a;
    w.c = w.c + w.b;
    w.b = rotl(w.b, 17) ^ w.c;
    w.c = rotl(w.c, 32);
    return w;
  endfunction

  // Keep the low cnt bytes of a word.
  function automatic logic [63:0] tail_mask(input logic [2:0] cnt);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < {1'b0, cnt}) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

@@ sv/sh_front.sv @@
// Front end: accept words, track message framing and length, build queue entries.
`timescale 1ns / 1ps

module sh_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [63:0]    message_word,
  input  logic [3:0]     byte_count,
  input  logic           last_word,
  input  logic           q_full,
  output logic           q_push,
  output sh_pkg::entry_t q_entry
);

  logic       in_message;
  logic [7:0] length_mod_256;
  logic       accept;
  logic       absorb;
  logic [2:0] tail_cnt;
  logic [7:0] len_base;
  logic [7:0] len_after;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    absorb    = !last_word || (byte_count >= 4'd8);
    tail_cnt  = absorb ? 3'd0 : byte_count[2:0];
    len_base  = in_message ? length_mod_256 : 8'd0;
    len_after = len_base + (absorb ? 8'd8 : 8'd0) + {5'd0, tail_cnt};

    q_entry.start  = !in_message;
    q_entry.absorb = absorb;
    q_entry.last   = last_word;
    q_entry.word   = message_word;
    q_entry.block  = (message_word & sh_pkg::tail_mask(tail_cnt) & {64{!absorb}}) |
                     ({56'd0, len_after} << sh_pkg::SIP_LEN_SHIFT);
  end

  // Close the message on its last word; the next word opens a new one.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message     <= 1'b0;
      length_mod_256 <= 8'd0;
    end else if (accept) begin
      in_message     <= !last_word;
      length_mod_256 <= last_word ? 8'd0 : len_after;
    end
  end

endmodule

@@ sv/sh_queue.sv @@
// Short FIFO of classified entries between front and back.
`timescale 1ns / 1ps

module sh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sh_pkg::entry_t wr_entry,
  output logic           full,
  input  logic           pop,
  output sh_pkg::entry_t rd_entry,
  output logic           valid
);

  sh_pkg::entry_t                mem [sh_pkg::QUEUE_DEPTH];
  logic [sh_pkg::QPTR_W-1:0]     wptr;
  logic [sh_pkg::QPTR_W-1:0]     rptr;
  logic [sh_pkg::QPTR_W:0]       count;
  logic                          do_push;
  logic                          do_pop;

  assign full     = (count == (sh_pkg::QPTR_W + 1)'(sh_pkg::QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign rd_entry = mem[rptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == (sh_pkg::QPTR_W)'(sh_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == (sh_pkg::QPTR_W)'(sh_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + {{sh_pkg::QPTR_W{1'b0}}, do_push} - {{sh_pkg::QPTR_W{1'b0}}, do_pop};
    end
  end

endmodule

@@ sv/sh_back.sv @@
// Back end: round sequencer over the lane registers and the result register.
`timescale 1ns / 1ps

module sh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    key_low,
  input  logic [63:0]    key_high,
  input  logic           q_valid,
  input  sh_pkg::entry_t q_entry,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [63:0]    mac_value
);

  localparam logic [2:0] S_IDLE = 3'd0;  // take an entry, run its first round
  localparam logic [2:0] S_W2   = 3'd1;  // second round of a full word
  localparam logic [2:0] S_F1   = 3'd2;  // first round of the final block
  localparam logic [2:0] S_F2   = 3'd3;  // second round of the final block
  localparam logic [2:0] S_X    = 3'd4;  // four finalization rounds
  localparam logic [2:0] S_OUT  = 3'd5;  // hand the MAC to the result register

  logic [2:0]    st;
  logic [2:0]    st_next;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  sh_pkg::lanes_t lanes;
  sh_pkg::lanes_t lanes_next;
  sh_pkg::lanes_t init_lanes;
  sh_pkg::lanes_t rin;
  sh_pkg::lanes_t rout;
  logic [63:0]   cur_word;
  logic [63:0]   cur_block;
  logic          cur_last;
  logic          out_valid;
  logic          out_load;

  assign init_lanes = '{a: sh_pkg::SIP_INIT_A ^ key_low,
                        b: sh_pkg::SIP_INIT_B ^ key_high,
                        c: sh_pkg::SIP_INIT_C ^ key_low,
                        d: sh_pkg::SIP_INIT_D ^ key_high};

  // Round input: lanes, or on entry pickup the (possibly fresh) lanes with the block mixed in.
  always_comb begin
    rin = lanes;
    if (st == S_IDLE) begin
      rin = q_entry.start ? init_lanes : lanes;
      rin.d = rin.d ^ (q_entry.absorb ? q_entry.word : q_entry.block);
    end
  end

  assign rout = sh_pkg::lane_round(rin);

  always_comb begin
    lanes_next = lanes;
    st_next    = st;
    cnt_next   = cnt;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (st)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          lanes_next = rout;
          st_next    = q_entry.absorb ? S_W2 : S_F2;
        end
      end
      S_W2: begin
        lanes_next   = rout;
        lanes_next.a = rout.a ^ cur_word;
        if (cur_last) begin
          lanes_next.d = rout.d ^ cur_block;
          st_next      = S_F1;
        end else begin
          st_next = S_IDLE;
        end
      end
      S_F1: begin
        lanes_next = rout;
        st_next    = S_F2;
      end
      S_F2: begin
        lanes_next   = rout;
        lanes_next.a = rout.a ^ cur_block;
        lanes_next.c = rout.c ^ sh_pkg::SIP_FINAL_XOR;
        cnt_next     = 2'd0;
        st_next      = S_X;
      end
      S_X: begin
        lanes_next = rout;
        cnt_next   = cnt + 2'd1;
        if (cnt == 2'd3) begin
          st_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || pop) begin
          out_load = 1'b1;
          st_next  = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      cnt       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      st  <= st_next;
      cnt <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lanes <= lanes_next;
    if (q_pop) begin
      cur_word  <= q_entry.word;
      cur_block <= q_entry.block;
      cur_last  <= q_entry.last;
    end
    if (out_load) begin
      mac_value <= lanes.a ^ lanes.b ^ lanes.c ^ lanes.d;
    end
  end

  assign empty = !out_valid;

endmodule

@@ sv/siphash_mac_engine.sv @@
// Top level of the SipHash-2-4 MAC engine: key registers, front, queue, back.
`timescale 1ns / 1ps

// Timing: a word is in the queue in the cycle after its transfer; the back takes a new
// entry only in S_IDLE and runs a full word through S_IDLE and S_W2, a last word through
// S_IDLE, S_F2, the finalization rounds in S_X and S_OUT (a full last word: S_IDLE, S_W2,
// S_F1, S_F2, S_X, S_OUT); S_OUT waits until the result register is free for the MAC.
// Rounds: one SipRound per cycle on the lane registers; the queue takes words while not full.
// Reset: synchronous rst clears the keys, the queue, the message framing and the result valid flag.
module siphash_mac_engine (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        push,
  output logic        full,
  input  logic [63:0] message_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [63:0] mac_value,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]    key_low;
  logic [63:0]    key_high;
  logic           cfg_write;
  logic           q_full;
  logic           q_push;
  logic           q_valid;
  logic           q_pop;
  sh_pkg::entry_t wr_entry;
  sh_pkg::entry_t rd_entry;

  // Keys are 64 bits wide, so they sit at byte addresses 0 and 8; paddr[3] picks one.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? key_high : key_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= 64'd0;
      key_high <= 64'd0;
    end else if (cfg_write) begin
      if (paddr[3]) begin
        key_high <= pwdata;
      end else begin
        key_low <= pwdata;
      end
    end
  end

  // Front: classify each word (message start, full absorb, tail block with length).
  sh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .message_word (message_word),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (wr_entry)
  );

  // Queue: decouple word intake from the multi-cycle round work.
  sh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .valid    (q_valid)
  );

  // Back: run rounds on the lanes and hold the finished MAC until its transfer.
  sh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .key_low   (key_low),
    .key_high  (key_high),
    .q_valid   (q_valid),
    .q_entry   (rd_entry),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .mac_value (mac_value)
  );

endmodule
